@@ hw/rtl/erv_pkg.sv @@
`default_nettype none

package erv_pkg;

  // Q2.14 coefficients
  localparam int COEF_W   = 16;
  localparam int NUM_COEF = 9;
  localparam int COEF_ONE = 16384;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t coef_mat_t [NUM_COEF];

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_CFG    = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COS_ALPHA = 3'd0,
    CFG_SIN_ALPHA = 3'd1,
    CFG_COS_BETA  = 3'd2,
    CFG_SIN_BETA  = 3'd3,
    CFG_COS_GAMMA = 3'd4,
    CFG_SIN_GAMMA = 3'd5
  } cfg_reg_t;

  // Q6.42 coefficient build: width and rounding shift down to Q2.14
  localparam int Q42_W       = 48;
  localparam int PAIR_W      = 32;
  localparam int Q42_SHIFT   = 28;
  localparam int Q42_RND_W   = Q42_W - Q42_SHIFT;

  // vertex products carry 30 fraction bits; results keep 16
  localparam int FRAC_DROP   = 14;
  localparam int SUM_GUARD   = 2;

endpackage

`default_nettype wire

@@ hw/rtl/erv_if.sv @@
`default_nettype none

// Input vertex channel
interface erv_in_if #(
  parameter int COORD_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] coord_x;
  logic signed [COORD_WIDTH-1:0] coord_y;
  logic signed [COORD_WIDTH-1:0] coord_z;
  logic                          last_in;

  modport source (output valid, coord_x, coord_y, coord_z, last_in, input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, last_in, output ready);
endinterface

// Rotated vertex channel
interface erv_out_if #(
  parameter int COORD_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] rot_x;
  logic signed [COORD_WIDTH-1:0] rot_y;
  logic signed [COORD_WIDTH-1:0] rot_z;
  logic                          last_out;

  modport source (output valid, rot_x, rot_y, rot_z, last_out, input ready);
  modport sink   (input valid, rot_x, rot_y, rot_z, last_out, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/erv_coef_build.sv @@
`default_nettype none

// Holds the six angle registers and rebuilds the 3x3 rotation matrix
// in three stages after every write to a valid register index.
module erv_coef_build
  import erv_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output coef_mat_t                  matrix,
  output logic                       busy
);

  typedef logic signed [PAIR_W-1:0] pair_t;
  typedef logic signed [Q42_W-1:0]  q42_t;

  // angle registers
  coef_t ca, sa, cb, sb, cg, sg;

  // build stage valid bits
  logic bv1, bv2, bv3;

  // stage A: pair products
  pair_t a_cacb, a_cgsa, a_casb, a_sasg, a_cbsa;
  pair_t a_cacg, a_sasb, a_casg, a_cbsg, a_cbcg;
  coef_t a_sb, a_sg;

  // stage B: triple products and delayed pairs
  q42_t  b_casbsg, b_cacgsb, b_sasbsg, b_cgsasb;
  pair_t b_cacb, b_cgsa, b_sasg, b_cbsa, b_cacg, b_casg, b_cbsg, b_cbcg;
  coef_t b_sb;

  q42_t  c_sum [NUM_COEF];

  function automatic q42_t k14(input pair_t p);
    q42_t t;
    t = Q42_W'(p);
    return t <<< FRAC_DROP;
  endfunction

  // round to nearest (ties up) down to Q2.14 and saturate
  function automatic coef_t q42_round(input q42_t v);
    q42_t                        t;
    logic signed [Q42_RND_W-1:0] r;
    t = v + (Q42_W'(1) <<< (Q42_SHIFT - 1));
    r = Q42_RND_W'(t >>> Q42_SHIFT);
    if (r > Q42_RND_W'(32767))
      return coef_t'(16'sh7FFF);
    else if (r < -Q42_RND_W'(32768))
      return coef_t'(16'sh8000);
    else
      return r[COEF_W-1:0];
  endfunction

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ca  <= coef_t'(COEF_ONE);
      sa  <= '0;
      cb  <= coef_t'(COEF_ONE);
      sb  <= '0;
      cg  <= coef_t'(COEF_ONE);
      sg  <= '0;
      bv1 <= 1'b0;
    end else begin
      bv1 <= 1'b0;
      if (cfg_we) begin
        bv1 <= 1'b1;
        case (cfg_idx)
          CFG_COS_ALPHA: ca <= cfg_data;
          CFG_SIN_ALPHA: sa <= cfg_data;
          CFG_COS_BETA:  cb <= cfg_data;
          CFG_SIN_BETA:  sb <= cfg_data;
          CFG_COS_GAMMA: cg <= cfg_data;
          CFG_SIN_GAMMA: sg <= cfg_data;
          default:       bv1 <= 1'b0;
        endcase
      end
    end
  end

  // stage A: 16x16 pair products
  always_ff @(posedge clk) begin
    a_cacb <= PAIR_W'(ca) * PAIR_W'(cb);
    a_cgsa <= PAIR_W'(cg) * PAIR_W'(sa);
    a_casb <= PAIR_W'(ca) * PAIR_W'(sb);
    a_sasg <= PAIR_W'(sa) * PAIR_W'(sg);
    a_cbsa <= PAIR_W'(cb) * PAIR_W'(sa);
    a_cacg <= PAIR_W'(ca) * PAIR_W'(cg);
    a_sasb <= PAIR_W'(sa) * PAIR_W'(sb);
    a_casg <= PAIR_W'(ca) * PAIR_W'(sg);
    a_cbsg <= PAIR_W'(cb) * PAIR_W'(sg);
    a_cbcg <= PAIR_W'(cb) * PAIR_W'(cg);
    a_sb   <= sb;
    a_sg   <= sg;
  end

  // stage B: 32x16 triple products
  always_ff @(posedge clk) begin
    b_casbsg <= Q42_W'(a_casb) * Q42_W'(a_sg);
    b_cacgsb <= Q42_W'(a_cacg) * Q42_W'(a_sb);
    b_sasbsg <= Q42_W'(a_sasb) * Q42_W'(a_sg);
    b_cgsasb <= Q42_W'(a_cgsa) * Q42_W'(a_sb);
    b_cacb   <= a_cacb;
    b_cgsa   <= a_cgsa;
    b_sasg   <= a_sasg;
    b_cbsa   <= a_cbsa;
    b_cacg   <= a_cacg;
    b_casg   <= a_casg;
    b_cbsg   <= a_cbsg;
    b_cbcg   <= a_cbcg;
    b_sb     <= a_sb;
  end

  // stage C: combine terms in Q6.42
  always_comb begin
    c_sum[0] = k14(b_cacb);
    c_sum[1] = k14(b_cgsa) - b_casbsg;
    c_sum[2] = -b_cacgsb - k14(b_sasg);
    c_sum[3] = -k14(b_cbsa);
    c_sum[4] = k14(b_cacg) + b_sasbsg;
    c_sum[5] = b_cgsasb - k14(b_casg);
    c_sum[6] = Q42_W'(b_sb) <<< Q42_SHIFT;
    c_sum[7] = k14(b_cbsg);
    c_sum[8] = k14(b_cbcg);
  end

  // valid chain and matrix update
  always_ff @(posedge clk) begin
    if (rst) begin
      bv2 <= 1'b0;
      bv3 <= 1'b0;
      for (int i = 0; i < NUM_COEF; i++) begin
        matrix[i] <= (i % 4 == 0) ? coef_t'(COEF_ONE) : '0;
      end
    end else begin
      bv2 <= bv1;
      bv3 <= bv2;
      if (bv3) begin
        for (int i = 0; i < NUM_COEF; i++) begin
          matrix[i] <= q42_round(c_sum[i]);
        end
      end
    end
  end

  assign busy = bv1 | bv2 | bv3;

endmodule

`default_nettype wire

@@ hw/rtl/euler_rotate_vertex.sv @@
`default_nettype none

// Z-Y-X Euler rotation of a stream of Q16.16 vertices. Software writes the
// cosine and sine of the three angles (Q2.14) through the write port; each
// write to a valid register index rebuilds the nine Q2.14 matrix
// coefficients in a three-stage build pipeline, and the input channel holds
// ready low during the write cycle and while the build is busy.
// Writes to indexes beyond the six registers are ignored. Vertices then flow
// through a four-stage pipeline (input register, nine coordinate-by-
// coefficient multipliers, row sums with rounding offset, shift and
// saturate into the output register): one vertex a cycle while no write or
// rebuild holds ready low, and a stalled output backs up only as far as the
// first empty stage. Results round to nearest (ties up) and saturate to
// COORD_WIDTH bits; last_out is last_in carried along.
module euler_rotate_vertex
  import erv_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  erv_in_if.sink                     vertex,
  erv_out_if.source                  result
);

  localparam int PW  = COORD_WIDTH + COEF_W;
  localparam int SW  = PW + SUM_GUARD;
  localparam int SHW = SW - FRAC_DROP;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [PW-1:0]          prod_t;
  typedef logic signed [SW-1:0]          sum_t;
  typedef logic signed [SHW-1:0]         shr_t;

  coef_mat_t matrix;
  logic      busy;

  erv_coef_build u_coef (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .matrix   (matrix),
    .busy     (busy)
  );

  // stage valid bits and per-stage advance
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;
  logic accept;

  assign en4 = ~v4 | result.ready;
  assign en3 = ~v3 | en4;
  assign en2 = ~v2 | en3;
  assign en1 = ~v1 | en2;

  assign vertex.ready = en1 & ~busy & ~cfg_we;
  assign accept       = vertex.valid & vertex.ready;

  // payload registers
  coord_t vec1 [3];
  logic   last1, last2, last3, last4;
  prod_t  prod2 [NUM_COEF];
  sum_t   sum3 [3];
  coord_t rot4 [3];
  shr_t   shr [3];
  coord_t sat [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= accept;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (en1) begin
      vec1[0] <= vertex.coord_x;
      vec1[1] <= vertex.coord_y;
      vec1[2] <= vertex.coord_z;
      last1   <= vertex.last_in;
    end
  end

  // stage 2: coordinate times coefficient, Q.30
  always_ff @(posedge clk) begin
    if (en2) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod2[r*3+c] <= PW'(vec1[c]) * PW'(matrix[r*3+c]);
        end
      end
      last2 <= last1;
    end
  end

  // stage 3: row sums plus half an output LSB
  always_ff @(posedge clk) begin
    if (en3) begin
      for (int r = 0; r < 3; r++) begin
        sum3[r] <= SW'(prod2[r*3]) + SW'(prod2[r*3+1]) + SW'(prod2[r*3+2])
                 + (SW'(1) <<< (FRAC_DROP - 1));
      end
      last3 <= last2;
    end
  end

  // stage 4: floor shift and saturate
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      shr[r] = SHW'(sum3[r] >>> FRAC_DROP);
      if (shr[r][SHW-1:COORD_WIDTH-1] == '0 || shr[r][SHW-1:COORD_WIDTH-1] == '1)
        sat[r] = shr[r][COORD_WIDTH-1:0];
      else if (shr[r][SHW-1])
        sat[r] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      else
        sat[r] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      for (int r = 0; r < 3; r++) begin
        rot4[r] <= sat[r];
      end
      last4 <= last3;
    end
  end

  assign result.valid    = v4;
  assign result.rot_x    = rot4[0];
  assign result.rot_y    = rot4[1];
  assign result.rot_z    = rot4[2];
  assign result.last_out = last4;

endmodule

`default_nettype wire

@@ hw/rtl/erv_checker.sv @@
`default_nettype none

module erv_checker
  import erv_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          cfg_we,
  input wire logic [CFG_IDX_W-1:0]          cfg_idx,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic signed [COORD_WIDTH-1:0] rot_x,
  input wire logic                          last_out
);

  // no vertex beat in the same cycle as a register write
  a_no_beat_on_write: assert property (@(posedge clk)
    cfg_we |-> !(in_valid && in_ready))
    else $error("vertex beat taken during a config write");

  // a real register write holds off input while the matrix rebuilds
  a_hold_after_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && cfg_idx < CFG_IDX_W'(NUM_CFG)) |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("input ready during coefficient rebuild");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(rot_x) && $stable(last_out))
    else $error("stalled result beat changed");

endmodule

bind euler_rotate_vertex erv_checker #(.COORD_WIDTH(COORD_WIDTH)) u_erv_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_we    (cfg_we),
  .cfg_idx   (cfg_idx),
  .in_valid  (vertex.valid),
  .in_ready  (vertex.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .rot_x     (result.rot_x),
  .last_out  (result.last_out)
);

`default_nettype wire

@@ tb/erv_rotation_checker.sv @@
`default_nettype none

// Watches the write port and both vertex channels, keeps its own copy of the
// angle registers and rotation matrix, and checks every rotated vertex.
module erv_rotation_checker
  import erv_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  erv_in_if                          vertex,
  erv_out_if                         result,
  output int                         errors,
  output int                         outstanding,
  output int                         vertices_in,
  output int                         results_out,
  output int                         cfg_writes
);

  localparam longint COORD_MAX   = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
  localparam longint COORD_MIN   = -COORD_MAX - 1;
  localparam longint COEF_MAX    = (longint'(1) <<< (COEF_W - 1)) - 1;
  localparam longint COEF_MIN    = -COEF_MAX - 1;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
    logic                          last;
  } rot_vertex_t;

  logic signed [CFG_DATA_W-1:0] angle_reg [NUM_CFG];
  coef_t                        rot_mat   [NUM_COEF];
  rot_vertex_t                  rotated_q [$];

  // Q6.42 -> Q2.14, round half up, saturate to 16 bits
  function automatic coef_t round_coef(input longint q42);
    longint r;
    r = (q42 + (longint'(1) <<< (Q42_SHIFT - 1))) >>> Q42_SHIFT;
    if (r > COEF_MAX) r = COEF_MAX;
    if (r < COEF_MIN) r = COEF_MIN;
    return coef_t'(r);
  endfunction

  // Z-Y-X matrix from the current angle registers, row major
  function automatic void build_matrix();
    longint ca, sa, cb, sb, cg, sg, k;
    ca = longint'(angle_reg[CFG_COS_ALPHA]);
    sa = longint'(angle_reg[CFG_SIN_ALPHA]);
    cb = longint'(angle_reg[CFG_COS_BETA]);
    sb = longint'(angle_reg[CFG_SIN_BETA]);
    cg = longint'(angle_reg[CFG_COS_GAMMA]);
    sg = longint'(angle_reg[CFG_SIN_GAMMA]);
    k  = COEF_ONE;
    rot_mat[0] = round_coef(ca * cb * k);
    rot_mat[1] = round_coef(cg * sa * k - ca * sb * sg);
    rot_mat[2] = round_coef(-(ca * cg * sb) - sa * sg * k);
    rot_mat[3] = round_coef(-(cb * sa * k));
    rot_mat[4] = round_coef(ca * cg * k + sa * sb * sg);
    rot_mat[5] = round_coef(cg * sa * sb - ca * sg * k);
    rot_mat[6] = round_coef(sb * k * k);
    rot_mat[7] = round_coef(cb * sg * k);
    rot_mat[8] = round_coef(cb * cg * k);
  endfunction

  // One output coordinate: Q.30 dot product, round ties up, saturate
  function automatic logic signed [COORD_WIDTH-1:0] rotate_row(
    input int row, input longint x, input longint y, input longint z);
    longint acc;
    longint r;
    acc = x * longint'(rot_mat[row*3]) + y * longint'(rot_mat[row*3+1])
        + z * longint'(rot_mat[row*3+2]);
    r = (acc + (longint'(1) <<< (FRAC_DROP - 1))) >>> FRAC_DROP;
    if (r > COORD_MAX) r = COORD_MAX;
    if (r < COORD_MIN) r = COORD_MIN;
    return r[COORD_WIDTH-1:0];
  endfunction

  task automatic check_field(input string field, input longint want, input longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    rot_vertex_t want;
    longint      vx, vy, vz;
    if (rst) begin
      // cosines reset to 1.0, sines to 0; matrix to identity
      for (int i = 0; i < NUM_CFG; i++)
        angle_reg[i] = (i % 2 == 0) ? CFG_DATA_W'(COEF_ONE) : '0;
      for (int i = 0; i < NUM_COEF; i++)
        rot_mat[i] = (i % 4 == 0) ? coef_t'(COEF_ONE) : '0;
      rotated_q.delete();
      outstanding = 0;
    end else begin
      // input beat: predict the rotated vertex
      if (vertex.valid && vertex.ready) begin
        vx = longint'(vertex.coord_x);
        vy = longint'(vertex.coord_y);
        vz = longint'(vertex.coord_z);
        want.x    = rotate_row(0, vx, vy, vz);
        want.y    = rotate_row(1, vx, vy, vz);
        want.z    = rotate_row(2, vx, vy, vz);
        want.last = vertex.last_in;
        rotated_q.push_back(want);
        vertices_in++;
      end
      // output beat: compare with the oldest prediction
      if (result.valid && result.ready) begin
        results_out++;
        if (rotated_q.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected: actual x %0d y %0d z %0d last %0b",
                   $time, result.rot_x, result.rot_y, result.rot_z, result.last_out);
        end else begin
          want = rotated_q.pop_front();
          check_field("rot_x", longint'(want.x), longint'(result.rot_x));
          check_field("rot_y", longint'(want.y), longint'(result.rot_y));
          check_field("rot_z", longint'(want.z), longint'(result.rot_z));
          check_field("last_out", longint'(want.last), longint'(result.last_out));
        end
      end
      // register write: spare indexes leave the matrix alone
      if (cfg_we && cfg_idx < NUM_CFG) begin
        angle_reg[cfg_idx] = cfg_data;
        build_matrix();
        cfg_writes++;
      end
      outstanding = rotated_q.size();
    end
  end

endmodule

`default_nettype wire

@@ tb/euler_rotate_vertex_test.sv @@
`default_nettype none

module euler_rotate_vertex_test;
  import erv_pkg::*;

  localparam int CW         = 32;
  localparam int MAX_IDLE   = 14;
  localparam int HOLD_CYCLES = 200;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_ITEMS = 100;
  localparam int DRAIN_LIMIT = 5000;

  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] ONE_Q16 = CW'(65536);

  localparam logic signed [CFG_DATA_W-1:0] UNIT     = CFG_DATA_W'(COEF_ONE);
  localparam logic signed [CFG_DATA_W-1:0] NEG_UNIT = -UNIT;
  localparam logic signed [CFG_DATA_W-1:0] HALF     = CFG_DATA_W'(COEF_ONE / 2);
  localparam logic signed [CFG_DATA_W-1:0] REG_MAX  = {1'b0, {(CFG_DATA_W-1){1'b1}}};
  localparam logic signed [CFG_DATA_W-1:0] REG_MIN  = {1'b1, {(CFG_DATA_W-1){1'b0}}};

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int errors, outstanding, vertices_in, results_out, cfg_writes;
  bit idle_on  = 1'b1;
  bit hold_out = 1'b0;
  bit stuck    = 1'b0;

  erv_in_if  #(.COORD_WIDTH(CW)) vin ();
  erv_out_if #(.COORD_WIDTH(CW)) vout ();

  euler_rotate_vertex #(.COORD_WIDTH(CW)) u_dut (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data),
    .vertex  (vin),
    .result  (vout)
  );

  erv_rotation_checker #(.COORD_WIDTH(CW)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .vertex     (vin),
    .result     (vout),
    .errors     (errors),
    .outstanding(outstanding),
    .vertices_in(vertices_in),
    .results_out(results_out),
    .cfg_writes (cfg_writes)
  );

  always #1 clk = ~clk;

  initial begin
    vin.valid   <= 1'b0;
    vin.coord_x <= '0;
    vin.coord_y <= '0;
    vin.coord_z <= '0;
    vin.last_in <= 1'b0;
    vout.ready  <= 1'b0;
  end

  // Run limit
  initial begin
    #400000;
    $display("euler_rotate_vertex_test: FAIL");
    $finish;
  end

  // Result side: random back-pressure, one long hold when asked
  initial begin : result_sink
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_out) begin
        stall    = HOLD_CYCLES;
        hold_out = 1'b0;
      end else begin
        stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (stall > 0) begin
        vout.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      vout.ready <= 1'b1;
      do @(posedge clk); while (!vout.valid);
    end
  end

  // Offer one vertex, after a random gap when idling is on; returns on the accepting edge
  task automatic put_vertex(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                            input logic signed [CW-1:0] z, input logic last);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      vin.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vin.valid   <= 1'b1;
    vin.coord_x <= x;
    vin.coord_y <= y;
    vin.coord_z <= z;
    vin.last_in <= last;
    do @(posedge clk); while (!vin.ready);
  endtask

  // Stop offering and wait until every rotated vertex has come back
  task automatic settle();
    vin.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_angles(input logic [CFG_DATA_W-1:0] ca, input logic [CFG_DATA_W-1:0] sa,
                            input logic [CFG_DATA_W-1:0] cb, input logic [CFG_DATA_W-1:0] sb,
                            input logic [CFG_DATA_W-1:0] cg, input logic [CFG_DATA_W-1:0] sg);
    settle();
    write_reg(CFG_COS_ALPHA, ca);
    write_reg(CFG_SIN_ALPHA, sa);
    write_reg(CFG_COS_BETA,  cb);
    write_reg(CFG_SIN_BETA,  sb);
    write_reg(CFG_COS_GAMMA, cg);
    write_reg(CFG_SIN_GAMMA, sg);
  endtask

  // Any Q2.14 value from -1.0 to +1.0
  function automatic logic [CFG_DATA_W-1:0] rand_trig();
    return CFG_DATA_W'(int'($urandom_range(0, 2 * COEF_ONE)) - COEF_ONE);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_unit();
    return $urandom_range(0, 1) ? UNIT : NEG_UNIT;
  endfunction

  // Mix of full-range, small, mid-range and corner coordinates
  function automatic logic [CW-1:0] rand_coord();
    logic [CW-1:0] corner [5];
    int pick;
    corner = '{CMAX, CMIN, '0, CW'(1), '1};
    pick = $urandom_range(0, 99);
    if (pick < 40) return CW'($urandom);
    if (pick < 65) return CW'(int'($urandom_range(0, 2097152)) - 1048576);
    if (pick < 80) return corner[$urandom_range(0, 4)];
    return CW'($signed($urandom) >>> 4);
  endfunction

  initial begin : stimulus
    int drain;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (rst);

    // identity matrix out of reset: pass-through, corners, fractions
    put_vertex('0, '0, '0, 1'b0);
    put_vertex(CMAX, CMIN, CW'(1), 1'b1);
    put_vertex(CMIN, CMAX, -CW'(1), 1'b0);
    put_vertex(CW'(32'h0001_8000), -CW'(5), CW'(7), 1'b1);

    // half scale on x and y: exact ties round toward +inf
    set_angles(HALF, '0, UNIT, '0, UNIT, '0);
    put_vertex(CW'(1), -CW'(1), CW'(5), 1'b0);
    put_vertex(-CW'(3), CW'(3), -CW'(7), 1'b1);

    // every register at +1.0, then -1.0: coefficients saturate, results saturate
    set_angles(UNIT, UNIT, UNIT, UNIT, UNIT, UNIT);
    put_vertex(CMAX, CMAX, CMAX, 1'b0);
    put_vertex(CMIN, CMIN, CMIN, 1'b1);
    set_angles(NEG_UNIT, NEG_UNIT, NEG_UNIT, NEG_UNIT, NEG_UNIT, NEG_UNIT);
    put_vertex(CMAX, CMIN, CMAX, 1'b0);
    put_vertex(CMIN, CMAX, CMIN, 1'b1);

    // registers beyond +-1.0 are taken as written
    set_angles(REG_MAX, REG_MIN, REG_MAX, REG_MIN, REG_MAX, REG_MIN);
    put_vertex(CMAX, CMAX, CMAX, 1'b0);
    put_vertex(CW'(12345), -CW'(54321), ONE_Q16, 1'b1);

    // 90 degrees about z, then writes to spare indexes must change nothing
    set_angles('0, UNIT, UNIT, '0, UNIT, '0);
    write_reg(CFG_IDX_W'(NUM_CFG), 16'h7abc);
    write_reg(CFG_IDX_W'(NUM_CFG + 1), 16'h8123);
    put_vertex(ONE_Q16, '0, '0, 1'b0);
    put_vertex('0, ONE_Q16, ONE_Q16, 1'b1);

    // 90 degrees about y and about x together
    set_angles(UNIT, '0, '0, UNIT, '0, UNIT);
    put_vertex(ONE_Q16, -ONE_Q16, CW'(3) * ONE_Q16, 1'b0);
    put_vertex(CMAX, CW'(777), CMIN, 1'b1);

    // random phases, each with its own matrix and idling pattern
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 3)
        set_angles(NEG_UNIT, UNIT, NEG_UNIT, UNIT, NEG_UNIT, UNIT);
      else if (p == 6)
        set_angles(rand_unit(), rand_unit(), rand_unit(), rand_unit(), rand_unit(),
                   rand_unit());
      else
        set_angles(rand_trig(), rand_trig(), rand_trig(), rand_trig(), rand_trig(),
                   rand_trig());
      write_reg(CFG_IDX_W'(NUM_CFG + p % 2), CFG_DATA_W'($urandom));
      idle_on = (p % 3 != 1);
      // one phase: sender streams while the result side holds off
      if (p == 4) begin
        idle_on  = 1'b0;
        hold_out = 1'b1;
      end
      for (int i = 0; i < PHASE_ITEMS; i++)
        put_vertex(rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 7) == 0);
    end

    // drain, then wait for stray beats
    vin.valid <= 1'b0;
    idle_on = 1'b1;
    drain   = 0;
    do begin
      @(posedge clk);
      drain++;
    end while (outstanding != 0 && drain < DRAIN_LIMIT);
    stuck = (outstanding != 0);
    repeat (8) @(posedge clk);

    $display("vertices in %0d, rotated vertices checked %0d, angle register writes %0d",
             vertices_in, results_out, cfg_writes);
    $display("matrices: identity, half scale, +-1.0 and over-range saturation, 90 degree axes, %0d random; mismatches %0d",
             NUM_PHASES, errors);
    if (errors == 0 && !stuck && outstanding == 0)
      $display("euler_rotate_vertex_test: PASS");
    else
      $display("euler_rotate_vertex_test: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/erv_pkg.sv
hw/rtl/erv_if.sv
hw/rtl/erv_coef_build.sv
hw/rtl/euler_rotate_vertex.sv
hw/rtl/erv_checker.sv
tb/erv_rotation_checker.sv
tb/euler_rotate_vertex_test.sv
